// File: sv/sqrot_pkg.sv
package sqrot_pkg;

  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd3;

  typedef logic signed [7:0] elem_t;
  typedef logic [SIZE_W-1:0] size_t;

endpackage

// File: sv/sqrot_in_if.sv
interface sqrot_in_if;
  logic valid;
  logic ready;
  sqrot_pkg::elem_t element_in;

  modport source (output valid, output element_in, input ready);
  modport sink (input valid, input element_in, output ready);
endinterface

// File: sv/sqrot_out_if.sv
interface sqrot_out_if;
  logic valid;
  logic ready;
  sqrot_pkg::elem_t element_out;
  logic frame_last;

  modport source (output valid, output element_out, output frame_last, input ready);
  modport sink (input valid, input element_out, input frame_last, output ready);
endinterface

// File: sv/sqrot_bank.sv
module sqrot_bank #(
  parameter int AW = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  sqrot_pkg::elem_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output sqrot_pkg::elem_t rdata
);

  // two banks addressed as {bank, row, col}
  sqrot_pkg::elem_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/square_matrix_rotate_90.sv
// square_matrix_rotate_90: rotates square frames of signed bytes by 90
// degrees counterclockwise.
// in_ch carries element_in in row-major order; out_ch carries element_out
// in row-major order of the rotated frame, with frame_last on its final item.
// cfg_we/cfg_wdata write size_in_use (side n, 0 taken as 1, values above
// MAX_DIM taken as MAX_DIM); a write restarts framing, so the next frame
// gives no output. Write it only while the block is idle.
// Each frame fills one bank of a two-bank RAM while the previous frame is
// read from the other bank, one rotated item per accepted item. The first
// frame after reset or after a size write produces nothing.
// Throughput: one item per cycle while out_ch does not stall, set by the single
// write and single read port of the bank RAM. An item's result passes through
// the RAM read register, loaded at the accepting edge, and then the output
// register, loaded once that register is free.
// Reset (rst, synchronous) clears framing and empties the pipeline; the
// RAM is not cleared and needs no clearing pass.
// When out_ch stalls, the output register and the read stage fill and
// in_ch.ready drops until out_ch takes an item.
module square_matrix_rotate_90 #(
  parameter int MAX_DIM = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  sqrot_pkg::size_t         cfg_wdata,
  sqrot_in_if.sink                 in_ch,
  sqrot_out_if.source              out_ch
);

  localparam int RW = $clog2(MAX_DIM);
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int CW = (NW > sqrot_pkg::SIZE_W) ? NW : sqrot_pkg::SIZE_W;
  localparam int AW = 1 + 2 * RW;

  sqrot_pkg::size_t size_in_use;
  logic [RW-1:0]    wrow;
  logic [RW-1:0]    wcol;
  logic             bank;
  logic             prev_ready;

  logic             s1_valid;
  logic             s1_last;
  sqrot_pkg::elem_t rd_data;

  logic             out_valid;
  sqrot_pkg::elem_t out_elem;
  logic             out_last;

  logic [CW-1:0]    size_ext;
  logic [NW-1:0]    n_eff;
  logic [NW-1:0]    n_m1;
  logic [RW-1:0]    rot_col;
  logic             col_end;
  logic             row_end;
  logic             acc;
  logic             out_free;
  logic             s1_adv;

  // clamp the side length
  always_comb begin
    size_ext = CW'(size_in_use);
    if (size_ext == '0) begin
      n_eff = NW'(1);
    end else if (size_ext > CW'(MAX_DIM)) begin
      n_eff = NW'(MAX_DIM);
    end else begin
      n_eff = NW'(size_ext);
    end
  end

  assign n_m1    = n_eff - NW'(1);
  assign rot_col = RW'(n_m1 - NW'(wrow));
  assign col_end = (NW'(wcol) == n_m1);
  assign row_end = (NW'(wrow) == n_m1);

  assign out_free    = !out_valid || out_ch.ready;
  assign s1_adv      = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;
  assign acc         = in_ch.valid && in_ch.ready;

  sqrot_bank #(
    .AW(AW)
  ) u_bank (
    .clk   (clk),
    .we    (acc),
    .waddr ({bank, wrow, wcol}),
    .wdata (in_ch.element_in),
    .re    (acc && prev_ready),
    .raddr ({~bank, wcol, rot_col}),
    .rdata (rd_data)
  );

  // framing counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= sqrot_pkg::SIZE_RESET;
      wrow        <= '0;
      wcol        <= '0;
      bank        <= 1'b0;
      prev_ready  <= 1'b0;
    end else if (cfg_we) begin
      size_in_use <= cfg_wdata;
      wrow        <= '0;
      wcol        <= '0;
      prev_ready  <= 1'b0;
    end else if (acc) begin
      if (col_end) begin
        wcol <= '0;
        if (row_end) begin
          wrow       <= '0;
          bank       <= ~bank;
          prev_ready <= 1'b1;
        end else begin
          wrow <= wrow + RW'(1);
        end
      end else begin
        wcol <= wcol + RW'(1);
      end
    end
  end

  // read stage tracks the item in the RAM read register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= prev_ready;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_last <= col_end && row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_elem <= rd_data;
      out_last <= s1_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.element_out = out_elem;
  assign out_ch.frame_last  = out_last;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    NW'(wcol) < n_eff && NW'(wrow) < n_eff)
    else $error("write position outside frame");

  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    acc && !cfg_we && col_end && row_end |=> prev_ready)
    else $error("completed frame not marked ready");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !prev_ready && wrow == '0 && wcol == '0)
    else $error("size write did not restart framing");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(rd_data))
    else $error("stalled read data lost");
`endif

endmodule

// File: sim/tb_square_matrix_rotate_90.sv
module tb_square_matrix_rotate_90;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 16;
  localparam int BANK_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MAX_GAP = 14;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct packed {
    sqrot_pkg::elem_t element_out;
    logic             frame_last;
  } rotated_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  sqrot_pkg::size_t cfg_wdata = sqrot_pkg::SIZE_RESET;
  logic             src_valid = 1'b0;
  sqrot_pkg::elem_t src_elem = '0;
  logic             snk_ready = 1'b0;

  sqrot_in_if in_if ();
  sqrot_out_if out_if ();

  assign in_if.valid = src_valid;
  assign in_if.element_in = src_elem;
  assign out_if.ready = snk_ready;

  square_matrix_rotate_90 #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always #1 clk = ~clk;

  // rotation predictor state
  sqrot_pkg::size_t side_reg = sqrot_pkg::SIZE_RESET;
  int               fill_row = 0;
  int               fill_col = 0;
  logic             fill_bank = 1'b0;
  logic             frame_held = 1'b0;
  sqrot_pkg::elem_t bank_mem [2][BANK_DEPTH];

  sqrot_pkg::elem_t pending_q [$];
  rotated_t         rotated_q [$];
  int               errors = 0;

  function automatic int eff_side(input sqrot_pkg::size_t s);
    if (s == 0) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return int'(s);
  endfunction

  // gap before the next item; now and then a run of back-to-back items
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic predict_rotation(input sqrot_pkg::elem_t x);
    int n;
    int r;
    int c;
    rotated_t e;
    n = eff_side(side_reg);
    r = (fill_row >= n) ? n - 1 : fill_row;
    c = (fill_col >= n) ? n - 1 : fill_col;
    if (frame_held) begin
      e.element_out = bank_mem[!fill_bank][c * n + (n - 1 - r)];
      e.frame_last = (r == n - 1) && (c == n - 1);
      rotated_q.push_back(e);
    end
    bank_mem[fill_bank][r * n + c] = x;
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) begin
        r = 0;
        fill_bank = !fill_bank;
        frame_held = 1'b1;
      end
    end
    fill_row = r;
    fill_col = c;
  endtask

  // driver
  int src_gap = 0;
  int src_quiet = 0;

  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      // a size write restarts framing, the banks are kept
      if (cfg_we) begin
        side_reg = cfg_wdata;
        fill_row = 0;
        fill_col = 0;
        frame_held = 1'b0;
      end
      if (src_valid && in_if.ready) begin
        predict_rotation(src_elem);
      end
      if (!src_valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          src_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          src_elem <= pending_q.pop_front();
          src_valid <= 1'b1;
          src_gap = draw_wait(src_quiet);
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int snk_stall = 0;
  int snk_quiet = 0;
  int hold_left = 0;
  int results_seen = 0;

  always @(posedge clk) begin
    rotated_t want;
    if (rst) begin
      snk_ready <= 1'b0;
    end else begin
      if (out_if.valid && snk_ready) begin
        results_seen++;
        if (rotated_q.size() == 0) begin
          $error("unexpected item: element_out %0d frame_last %0b",
                 out_if.element_out, out_if.frame_last);
          errors++;
        end else begin
          want = rotated_q.pop_front();
          if (out_if.element_out !== want.element_out) begin
            $error("element_out: expected %0d, actual %0d",
                   want.element_out, out_if.element_out);
            errors++;
          end
          if (out_if.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, actual %0b",
                   want.frame_last, out_if.frame_last);
            errors++;
          end
        end
        // long hold-off so the block backs up into its input
        if (results_seen == 300 || results_seen == 900)
          hold_left = HOLD_CYCLES;
        else
          snk_stall = draw_wait(snk_quiet);
      end
      if (hold_left > 0) begin
        hold_left--;
        snk_ready <= 1'b0;
      end else if (snk_stall > 0) begin
        snk_stall--;
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= 1'b1;
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((src_valid && in_if.ready) || (out_if.valid && snk_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || src_valid || rotated_q.size() != 0)
      @(negedge clk);
    // items of a first frame give nothing but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(input sqrot_pkg::size_t v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input sqrot_pkg::size_t v, input int frames, input int extra);
    int n;
    sqrot_pkg::elem_t x;
    n = eff_side(v);
    write_side(v);
    @(negedge clk);
    repeat (frames * n * n + extra) begin
      if ($urandom_range(0, 7) == 0)
        x = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
      else
        x = sqrot_pkg::elem_t'($urandom_range(0, 255));
      pending_q.push_back(x);
    end
    wait_idle();
  endtask

  initial begin
    int total;
    int n;
    int frames;
    int extra;
    sqrot_pkg::size_t v;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset size: two full frames, then a partial one cut by the next write
    @(negedge clk);
    pending_q = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1, 8'sd1, 8'sd85, -8'sd86, 8'sd64, -8'sd65,
                  8'sd127, -8'sd128, -8'sd1, 8'sd0, 8'sd127, -8'sd128, 8'sd15, -8'sd16, 8'sd2,
                  8'sd127, -8'sd128, 8'sd0, -8'sd1};
    wait_idle();

    run_phase(sqrot_pkg::size_t'(0), 3, 0);   // zero taken as one
    run_phase(sqrot_pkg::size_t'(1), 2, 0);
    run_phase(sqrot_pkg::size_t'(2), 2, 3);
    run_phase(sqrot_pkg::size_t'(16), 2, 0);
    run_phase(sqrot_pkg::size_t'(31), 1, 40); // above max taken as max, restart mid-frame

    total = 0;
    while (total < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        v = sqrot_pkg::size_t'($urandom_range(10, 15));
      else
        v = sqrot_pkg::size_t'($urandom_range(0, 9));
      n = eff_side(v);
      frames = (n > 8) ? 2 : $urandom_range(2, 5);
      extra = (n > 1 && $urandom_range(0, 1) == 1) ? $urandom_range(1, n * n - 1) : 0;
      run_phase(v, frames, extra);
      total += frames * n * n + extra;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && rotated_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
sv/sqrot_pkg.sv
sv/sqrot_in_if.sv
sv/sqrot_out_if.sv
sv/sqrot_bank.sv
sv/square_matrix_rotate_90.sv
sim/tb_square_matrix_rotate_90.sv
